@@ hw/rtl/chl_pkg.sv @@
`default_nettype none

package chl_pkg;

    localparam int TimeWidth   = 32;
    localparam int TempWidth   = 12;
    localparam int BandWidth   = 9;
    localparam int LimitWidth  = 8;
    localparam int FanWidth    = 8;
    localparam int ErrWidth    = 3;
    localparam int AddrWidth   = 5;
    localparam int DataWidth   = 32;
    localparam int RegIdxWidth = 3;

    // Comparisons are made on sums that can exceed the temperature range.
    localparam int CmpWidth = TempWidth + 2;

    localparam logic signed [TempWidth-1:0]  SetpointReset   = 12'sd320;
    localparam logic [BandWidth-1:0]         BandReset       = 9'd32;
    localparam logic [TimeWidth-1:0]         ValveLockReset  = 32'd30000;
    localparam logic [TimeWidth-1:0]         CompLockReset   = 32'd60000;
    localparam logic [LimitWidth-1:0]        HighLimitReset  = 8'd30;
    localparam logic [LimitWidth-1:0]        LowLimitReset   = 8'd5;

    typedef enum logic [ErrWidth-1:0] {
        ERR_NONE   = 3'd0,
        ERR_READ   = 3'd1,
        ERR_HOT    = 3'd2,
        ERR_COLD   = 3'd3,
        ERR_NOFLOW = 3'd4
    } err_code_t;

    typedef enum logic [RegIdxWidth-1:0] {
        REG_SETPOINT   = 3'd0,
        REG_BAND       = 3'd1,
        REG_VALVE_LOCK = 3'd2,
        REG_COMP_LOCK  = 3'd3,
        REG_HIGH_LIMIT = 3'd4,
        REG_LOW_LIMIT  = 3'd5,
        REG_RUN_ENABLE = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic signed [TempWidth-1:0] setpoint;
        logic [BandWidth-1:0]        hysteresis_band;
        logic [TimeWidth-1:0]        valve_lockout_ms;
        logic [TimeWidth-1:0]        compressor_lockout_ms;
        logic [LimitWidth-1:0]       temp_high_limit;
        logic [LimitWidth-1:0]       temp_low_limit;
        logic                        run_enable;
    } cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/chl_if.sv @@
`default_nettype none

interface chl_in_if;
    logic                                      valid;
    logic                                      ready;
    logic [chl_pkg::TimeWidth-1:0]             now_ms;
    logic signed [chl_pkg::TempWidth-1:0]      res_temp;
    logic                                      temp_valid;
    logic                                      pump_on;
    logic                                      flow_switch_high;

    modport source (
        output valid, now_ms, res_temp, temp_valid, pump_on, flow_switch_high,
        input  ready
    );
    modport sink (
        input  valid, now_ms, res_temp, temp_valid, pump_on, flow_switch_high,
        output ready
    );
endinterface

interface chl_out_if;
    logic                                valid;
    logic                                ready;
    logic                                valve_relay;
    logic                                compressor_relay;
    logic [chl_pkg::FanWidth-1:0]        fan_level;
    logic [chl_pkg::ErrWidth-1:0]        fault_code;

    modport source (
        output valid, valve_relay, compressor_relay, fan_level, fault_code,
        input  ready
    );
    modport sink (
        input  valid, valve_relay, compressor_relay, fan_level, fault_code,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/chl_cfg.sv @@
`default_nettype none

module chl_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [chl_pkg::AddrWidth-1:0]    paddr,
    input  wire logic [chl_pkg::DataWidth-1:0]    pwdata,
    output logic      [chl_pkg::DataWidth-1:0]    prdata,
    output logic                                  pready,
    output chl_pkg::cfg_t                         cfg
);

    chl_pkg::cfg_t cfg_reg;
    chl_pkg::cfg_t cfg_next;
    logic [chl_pkg::RegIdxWidth-1:0] reg_idx;
    logic wr_en;

    // Registers sit on word boundaries, so the low address bits are ignored.
    assign reg_idx = paddr[chl_pkg::AddrWidth-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                chl_pkg::REG_SETPOINT:
                    cfg_next.setpoint = pwdata[chl_pkg::TempWidth-1:0];
                chl_pkg::REG_BAND:
                    cfg_next.hysteresis_band = pwdata[chl_pkg::BandWidth-1:0];
                chl_pkg::REG_VALVE_LOCK:
                    cfg_next.valve_lockout_ms = pwdata[chl_pkg::TimeWidth-1:0];
                chl_pkg::REG_COMP_LOCK:
                    cfg_next.compressor_lockout_ms = pwdata[chl_pkg::TimeWidth-1:0];
                chl_pkg::REG_HIGH_LIMIT:
                    cfg_next.temp_high_limit = pwdata[chl_pkg::LimitWidth-1:0];
                chl_pkg::REG_LOW_LIMIT:
                    cfg_next.temp_low_limit = pwdata[chl_pkg::LimitWidth-1:0];
                chl_pkg::REG_RUN_ENABLE:
                    cfg_next.run_enable = pwdata[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint              <= chl_pkg::SetpointReset;
            cfg_reg.hysteresis_band       <= chl_pkg::BandReset;
            cfg_reg.valve_lockout_ms      <= chl_pkg::ValveLockReset;
            cfg_reg.compressor_lockout_ms <= chl_pkg::CompLockReset;
            cfg_reg.temp_high_limit       <= chl_pkg::HighLimitReset;
            cfg_reg.temp_low_limit        <= chl_pkg::LowLimitReset;
            cfg_reg.run_enable            <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            chl_pkg::REG_SETPOINT:
                prdata = {{(chl_pkg::DataWidth-chl_pkg::TempWidth){cfg_reg.setpoint[
                    chl_pkg::TempWidth-1]}}, cfg_reg.setpoint};
            chl_pkg::REG_BAND:
                prdata = {{(chl_pkg::DataWidth-chl_pkg::BandWidth){1'b0}},
                    cfg_reg.hysteresis_band};
            chl_pkg::REG_VALVE_LOCK:
                prdata = cfg_reg.valve_lockout_ms;
            chl_pkg::REG_COMP_LOCK:
                prdata = cfg_reg.compressor_lockout_ms;
            chl_pkg::REG_HIGH_LIMIT:
                prdata = {{(chl_pkg::DataWidth-chl_pkg::LimitWidth){1'b0}},
                    cfg_reg.temp_high_limit};
            chl_pkg::REG_LOW_LIMIT:
                prdata = {{(chl_pkg::DataWidth-chl_pkg::LimitWidth){1'b0}},
                    cfg_reg.temp_low_limit};
            chl_pkg::REG_RUN_ENABLE:
                prdata = {{(chl_pkg::DataWidth-1){1'b0}}, cfg_reg.run_enable};
            default:
                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/chiller_hysteresis_lockout_control.sv @@
// Chiller thermostat with hysteresis and compressor anti-short-cycle lockout.
//
// Input channel in_ch carries one control pass per word: the millisecond
// timestamp, the reservoir temperature with its valid flag, the pump state and
// the flow switch. Output channel out_ch returns one word per pass with the
// valve relay, compressor relay, fan duty and the sticky last-error code.
// Both channels use valid/ready; a word moves when both are high.
//
// A pass is registered in the input stage on acceptance and evaluated once
// the result register is free; the controller state and the result register
// are updated together. One pass per cycle is sustained while out_ch.ready
// stays high; the only loop is the update of the controller state.
// While the receiver stalls, the result holds and one further pass waits in
// the input register; in_ch.ready then drops until out_ch.ready returns.
//
// Reset clears both stages, closes the valve, stops compressor and fan,
// zeroes both timers and the error code and loads the default settings.
// Settings are written over the APB port and should change only while idle.
`default_nettype none

module chiller_hysteresis_lockout_control (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    chl_in_if.sink                                in_ch,
    chl_out_if.source                             out_ch,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [chl_pkg::AddrWidth-1:0]    paddr,
    input  wire logic [chl_pkg::DataWidth-1:0]    pwdata,
    output logic      [chl_pkg::DataWidth-1:0]    prdata,
    output logic                                  pready
);

    localparam int Cw = chl_pkg::CmpWidth;
    localparam int Tw = chl_pkg::TempWidth;

    chl_pkg::cfg_t cfg;

    chl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input stage
    logic                              s1_valid_reg;
    logic [chl_pkg::TimeWidth-1:0]     s1_now_reg;
    logic signed [Tw-1:0]              s1_temp_reg;
    logic                              s1_tvalid_reg;
    logic                              s1_pump_reg;
    logic                              s1_noflow_reg;

    // Controller state, whose relay and error registers also form the result word
    logic                              out_valid_reg;
    logic [chl_pkg::TimeWidth-1:0]     last_comp_reg;
    logic [chl_pkg::TimeWidth-1:0]     last_valve_reg;
    logic                              valve_reg;
    logic                              comp_reg;
    chl_pkg::err_code_t                err_reg;

    logic [chl_pkg::TimeWidth-1:0]     last_comp_next;
    logic [chl_pkg::TimeWidth-1:0]     last_valve_next;
    logic                              valve_next;
    logic                              comp_next;
    chl_pkg::err_code_t                err_next;

    logic advance;
    logic in_fire;

    logic signed [Cw-1:0]          temp_c;
    logic signed [Cw-1:0]          setpoint_c;
    logic signed [Cw-1:0]          band_c;
    logic signed [Cw-1:0]          high_c;
    logic signed [Cw-1:0]          low_c;
    logic [chl_pkg::TimeWidth-1:0] comp_elapsed;
    logic [chl_pkg::TimeWidth-1:0] valve_elapsed;
    logic                          is_hot;
    logic                          is_cold;
    logic                          comp_ok;
    logic                          valve_ok;

    assign advance     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || advance;
    assign in_fire     = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_now_reg    <= in_ch.now_ms;
            s1_temp_reg   <= in_ch.res_temp;
            s1_tvalid_reg <= in_ch.temp_valid;
            s1_pump_reg   <= in_ch.pump_on;
            s1_noflow_reg <= in_ch.flow_switch_high;
        end
    end

    // A failed read is treated as a temperature of zero.
    assign temp_c = s1_tvalid_reg ? {{(Cw-Tw){s1_temp_reg[Tw-1]}}, s1_temp_reg} : '0;
    assign setpoint_c = {{(Cw-Tw){cfg.setpoint[Tw-1]}}, cfg.setpoint};
    assign band_c = {{(Cw-chl_pkg::BandWidth){1'b0}}, cfg.hysteresis_band};
    assign high_c = {{(Cw-chl_pkg::LimitWidth-4){1'b0}}, cfg.temp_high_limit, 4'b0000};
    assign low_c  = {{(Cw-chl_pkg::LimitWidth-4){1'b0}}, cfg.temp_low_limit, 4'b0000};

    assign comp_elapsed  = s1_now_reg - last_comp_reg;
    assign valve_elapsed = s1_now_reg - last_valve_reg;
    assign comp_ok  = comp_elapsed >= cfg.compressor_lockout_ms;
    assign valve_ok = valve_elapsed >= cfg.valve_lockout_ms;
    assign is_hot   = temp_c > (setpoint_c + band_c);
    assign is_cold  = temp_c <= (setpoint_c - band_c);

    always_comb
    begin
        last_comp_next  = last_comp_reg;
        last_valve_next = last_valve_reg;
        valve_next      = valve_reg;
        comp_next       = comp_reg;
        err_next        = err_reg;

        // Later checks take precedence over earlier ones.
        if (!s1_tvalid_reg)
        begin
            err_next = chl_pkg::ERR_READ;
        end
        if (temp_c > high_c)
        begin
            err_next = chl_pkg::ERR_HOT;
        end
        if (temp_c < low_c)
        begin
            err_next = chl_pkg::ERR_COLD;
        end

        if (cfg.run_enable)
        begin
            if (is_hot)
            begin
                if (valve_reg)
                begin
                    last_valve_next = s1_now_reg;
                    valve_next      = 1'b0;
                end
                // Elapsed times are those at the start of the pass, so the
                // compressor may start in the same pass the valve opens.
                if (valve_ok && comp_ok)
                begin
                    last_comp_next = s1_now_reg;
                    comp_next      = 1'b1;
                end
            end
            if (is_cold && comp_ok)
            begin
                last_comp_next  = s1_now_reg;
                last_valve_next = s1_now_reg;
                comp_next       = 1'b0;
                valve_next      = 1'b1;
            end
            if (s1_pump_reg && s1_noflow_reg)
            begin
                err_next = chl_pkg::ERR_NOFLOW;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            last_comp_reg  <= '0;
            last_valve_reg <= '0;
            valve_reg      <= 1'b1;
            comp_reg       <= 1'b0;
            err_reg        <= chl_pkg::ERR_NONE;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                last_comp_reg  <= last_comp_next;
                last_valve_reg <= last_valve_next;
                valve_reg      <= valve_next;
                comp_reg       <= comp_next;
                err_reg        <= err_next;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The state only changes when a pass is evaluated, so it doubles as the
    // result word and holds steady while the receiver stalls.
    assign out_ch.valid            = out_valid_reg;
    assign out_ch.valve_relay      = valve_reg;
    assign out_ch.compressor_relay = comp_reg;
    assign out_ch.fan_level        = {chl_pkg::FanWidth{comp_reg}};
    assign out_ch.fault_code       = err_reg;

    // The compressor never runs with the valve closed.
    a_comp_needs_valve: assert property (@(posedge clk) disable iff (!rst_n)
        comp_reg |-> !valve_reg)
        else $error("compressor running with valve closed");

    // A compressor start stamps its timer with the time of that pass.
    a_comp_start_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(comp_reg) |-> last_comp_reg == $past(s1_now_reg))
        else $error("compressor start without timer update");

    // State and result hold whenever no pass is evaluated.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(comp_reg) && $stable(valve_reg) && $stable(err_reg)
            && $stable(last_comp_reg) && $stable(last_valve_reg))
        else $error("controller state changed without a pass");

endmodule

`default_nettype wire
